[rtl/stp_pkg.sv]
// Shared constants and types for the stepper step/direction generator.
package stp_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 12;
    localparam int HALF_W     = 16;
    localparam int TICK_W     = 16;
    localparam int SCALE_W    = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = BYTE_W + HALF_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HALF_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SCALE    = 8'd1;

    localparam logic [HALF_W-1:0]  MAX_HALF_RESET = 16'd20;
    localparam logic [SCALE_W-1:0] SCALE_RESET    = 4'd3;
    localparam logic [HALF_W-1:0]  HALF_RESET     = 16'd5;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_FRAME = 1'b1;

    // half-up rounding offset for the divide by 255
    localparam logic [PROD_W-1:0] ROUND_OFS = 24'd127;
    localparam logic [PROD_W:0]   DIV_255   = 25'd255;

    typedef enum logic [2:0] {
        PH_DECIDE = 3'b001,
        PH_HIGH   = 3'b010,
        PH_LOW    = 3'b100
    } phase_t;

endpackage

[rtl/stp_if.sv]
// Channel interfaces: request, result and configuration write.
interface stp_req_if
    import stp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [BYTE_W-1:0] position_byte;
    logic [BYTE_W-1:0] speed_byte;

    modport source (output valid, req_type, position_byte, speed_byte, input ready);
    modport sink   (input valid, req_type, position_byte, speed_byte, output ready);
endinterface

interface stp_res_if
    import stp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             step_level;
    logic             direction_level;
    logic [POS_W-1:0] position;
    logic             at_target;

    modport source (output valid, step_level, direction_level, position, at_target,
                    input ready);
    modport sink   (input valid, step_level, direction_level, position, at_target,
                    output ready);
endinterface

interface stp_cfg_if
    import stp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/stp_half_calc.sv]
// Half period from speed*max product: max - round(product / 255), no divider.
module stp_half_calc
    import stp_pkg::*;
(
    input  logic [PROD_W-1:0] prod,
    input  logic [HALF_W-1:0] max_half,
    output logic [HALF_W-1:0] half
);

    logic [PROD_W-1:0] x;
    logic [PROD_W:0]   sum;
    logic [PROD_W-8:0] q0;
    logic [PROD_W:0]   q0_x255;
    logic [PROD_W:0]   rem;
    logic [PROD_W-8:0] dec;

    always_comb
    begin
        x = prod + ROUND_OFS;
        // x/255 ~= (x + x/256 + x/65536) / 256, low by at most one
        sum = {1'b0, x} + {9'b0, x[PROD_W-1:8]} + {17'b0, x[PROD_W-1:16]};
        q0 = sum[PROD_W:8];
        q0_x255 = {q0, 8'b0} - {8'b0, q0};
        rem = {1'b0, x} - q0_x255;
        dec = (rem >= DIV_255) ? q0 + 17'd1 : q0;
        if (dec <= {1'b0, max_half})
        begin
            half = max_half - dec[HALF_W-1:0];
        end
        else
        begin
            half = '0;
        end
    end

endmodule

[rtl/stepper_axis_step_dir_generator.sv]
// Top level: step/direction pulse generator for one stepper axis.
//
// Channels: req takes ticks (req_type 0) and control frames (req_type 1,
// carrying position_byte and speed_byte). Every request gives exactly one
// result on res: step line, direction line, position and at-target flag
// as they stand after that request. cfg writes max_half_period (index 0)
// and target_scale (index 1); it is always ready and may only be used
// while no request is in flight.
// A request passes an input register that also holds the speed*max and
// position*scale products, then the state update and the divide-by-255
// rounding feeding the result register. Throughput is one request per
// cycle while res takes results; the state registers close their loop
// through the combinational next-state logic.
// When res stalls, the result register holds and the input register takes
// one more request; req.ready then drops until res drains.
// Reset clears position, target and tick count, sets the half period to 5,
// the phase to decide, both lines low, and loads the register defaults.
module stepper_axis_step_dir_generator
    import stp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    stp_req_if.sink   req,
    stp_res_if.source res,
    stp_cfg_if.sink   cfg
);

    // configuration
    logic [HALF_W-1:0]  max_half_reg;
    logic [SCALE_W-1:0] scale_reg;

    // input stage
    logic              s1_valid_reg;
    logic              s1_type_reg;
    logic [POS_W-1:0]  s1_target_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              s1_adv;
    logic              req_fire;

    // axis state
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [POS_W-1:0]  target_reg, target_next;
    logic [HALF_W-1:0] half_reg,   half_next;
    logic [TICK_W-1:0] tick_reg,   tick_next;
    phase_t            phase_reg,  phase_next;
    logic              dir_reg,    dir_next;
    logic              pulse_reg,  pulse_next;
    logic              do_decide;
    logic [HALF_W-1:0] frame_half;

    // result register
    logic              out_valid_reg;
    logic              out_step_reg;
    logic              out_dir_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_at_target_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_half_reg <= MAX_HALF_RESET;
            scale_reg    <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_MAX_HALF_PERIOD)
            begin
                max_half_reg <= cfg.data;
            end
            else if (cfg.index == CFG_TARGET_SCALE)
            begin
                scale_reg <= cfg.data[SCALE_W-1:0];
            end
        end
    end

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_type_reg   <= req.req_type;
            s1_target_reg <= {4'b0, req.position_byte} * {8'b0, scale_reg};
            s1_prod_reg   <= {16'b0, req.speed_byte} * {8'b0, max_half_reg};
        end
    end

    stp_half_calc u_half_calc (
        .prod     (s1_prod_reg),
        .max_half (max_half_reg),
        .half     (frame_half)
    );

    always_comb
    begin
        pos_next    = pos_reg;
        target_next = target_reg;
        half_next   = half_reg;
        tick_next   = tick_reg;
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        pulse_next  = pulse_reg;
        do_decide   = 1'b0;

        if (s1_type_reg == REQ_FRAME)
        begin
            target_next = s1_target_reg;
            half_next   = frame_half;
        end
        else
        begin
            case (phase_reg)
                PH_HIGH:
                begin
                    if (tick_reg >= half_reg)
                    begin
                        pulse_next = 1'b0;
                        tick_next  = 16'd1;
                        phase_next = PH_LOW;
                    end
                    else
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                end
                PH_LOW:
                begin
                    if (tick_reg >= half_reg)
                    begin
                        do_decide = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                end
                default:
                begin
                    do_decide = 1'b1;
                end
            endcase
        end

        // the line only rises when a step is actually taken
        if (do_decide)
        begin
            if (target_reg > pos_reg)
            begin
                dir_next   = 1'b1;
                pos_next   = pos_reg + 12'd1;
                pulse_next = 1'b1;
            end
            else if (target_reg < pos_reg)
            begin
                dir_next   = 1'b0;
                pos_next   = pos_reg - 12'd1;
                pulse_next = 1'b1;
            end
            else
            begin
                pulse_next = 1'b0;
            end
            tick_next  = 16'd1;
            phase_next = PH_HIGH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            target_reg <= '0;
            half_reg   <= HALF_RESET;
            tick_reg   <= '0;
            phase_reg  <= PH_DECIDE;
            dir_reg    <= 1'b0;
            pulse_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            pos_reg    <= pos_next;
            target_reg <= target_next;
            half_reg   <= half_next;
            tick_reg   <= tick_next;
            phase_reg  <= phase_next;
            dir_reg    <= dir_next;
            pulse_reg  <= pulse_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_step_reg      <= pulse_next;
            out_dir_reg       <= dir_next;
            out_pos_reg       <= pos_next;
            out_at_target_reg <= (pos_next == target_next);
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.step_level      = out_step_reg;
    assign res.direction_level = out_dir_reg;
    assign res.position        = out_pos_reg;
    assign res.at_target       = out_at_target_reg;

endmodule

[bench/axis_motion_checker.sv]
// Motion predictor and result comparison for the step/direction generator.
`timescale 1ns / 100ps

module axis_motion_checker
    import stp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    stp_req_if   req,
    stp_res_if   res,
    stp_cfg_if   cfg,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic             step_level;
        logic             direction_level;
        logic [POS_W-1:0] position;
        logic             at_target;
    } axis_sample_t;

    axis_sample_t expected_q[$];

    // register copies
    logic [HALF_W-1:0]  max_half;
    logic [SCALE_W-1:0] scale;

    // predicted axis state
    logic [POS_W-1:0]  pos_cnt;
    logic [POS_W-1:0]  tgt_cnt;
    logic [HALF_W-1:0] half_ticks;
    phase_t            ph;
    logic [TICK_W-1:0] ticks_in_half;
    logic              dir_q;
    logic              step_q;

    int bad;

    assign mismatches = bad;

    function automatic void decide_step();
        step_q = 1'b0;
        if (tgt_cnt > pos_cnt)
        begin
            dir_q   = 1'b1;
            pos_cnt = pos_cnt + 1'b1;
            step_q  = 1'b1;
        end
        else if (tgt_cnt < pos_cnt)
        begin
            dir_q   = 1'b0;
            pos_cnt = pos_cnt - 1'b1;
            step_q  = 1'b1;
        end
        ticks_in_half = 16'd1;
        ph            = PH_HIGH;
    endfunction

    function automatic void advance_tick();
        case (ph)
            PH_HIGH:
            begin
                if (ticks_in_half >= half_ticks)
                begin
                    step_q        = 1'b0;
                    ticks_in_half = 16'd1;
                    ph            = PH_LOW;
                end
                else
                begin
                    ticks_in_half = ticks_in_half + 1'b1;
                end
            end
            PH_LOW:
            begin
                if (ticks_in_half >= half_ticks)
                    decide_step();
                else
                    ticks_in_half = ticks_in_half + 1'b1;
            end
            default:
            begin
                decide_step();
            end
        endcase
    endfunction

    // half period = max - round(speed * max / 255), done in integers
    function automatic void apply_frame(logic [BYTE_W-1:0] pb, logic [BYTE_W-1:0] sb);
        int unsigned s;
        int unsigned m;
        int unsigned dec;
        int unsigned tgt;
        s   = sb;
        m   = max_half;
        dec = (s * m * 2 + 255) / 510;
        tgt = pb * scale;
        tgt_cnt    = tgt[POS_W-1:0];
        half_ticks = (dec <= m) ? HALF_W'(m - dec) : '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        axis_sample_t got;
        axis_sample_t want;
        if (!rst_n)
        begin
            max_half      = MAX_HALF_RESET;
            scale         = SCALE_RESET;
            pos_cnt       = '0;
            tgt_cnt       = '0;
            half_ticks    = HALF_RESET;
            ph            = PH_DECIDE;
            ticks_in_half = '0;
            dir_q         = 1'b0;
            step_q        = 1'b0;
            bad           = 0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_MAX_HALF_PERIOD: max_half = cfg.data[HALF_W-1:0];
                    CFG_TARGET_SCALE:    scale    = cfg.data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_FRAME)
                    apply_frame(req.position_byte, req.speed_byte);
                else
                    advance_tick();
                expected_q.push_back('{step_q, dir_q, pos_cnt, pos_cnt == tgt_cnt});
            end

            if (res.valid && res.ready)
            begin
                got = '{res.step_level, res.direction_level, res.position, res.at_target};
                if (expected_q.size() == 0)
                begin
                    if (bad < 10)
                        $display("%0t: unexpected result step=%0b dir=%0b pos=%0d at=%0b",
                                 $realtime, got.step_level, got.direction_level,
                                 got.position, got.at_target);
                    bad++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.step_level !== want.step_level
                        || got.direction_level !== want.direction_level
                        || got.position !== want.position
                        || got.at_target !== want.at_target)
                    begin
                        if (bad < 10)
                        begin
                            $display("%0t: mismatch exp step=%0b dir=%0b pos=%0d at=%0b",
                                     $realtime, want.step_level, want.direction_level,
                                     want.position, want.at_target);
                            $display("%0t:          got step=%0b dir=%0b pos=%0d at=%0b",
                                     $realtime, got.step_level, got.direction_level,
                                     got.position, got.at_target);
                        end
                        bad++;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

[bench/testbench.sv]
// Top of the bench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps

module testbench
    import stp_pkg::*;
();

    localparam int IDLE_LIMIT = 5000;
    localparam int SEG_ITEMS  = 154;

    logic clk;
    logic rst_n;
    int   pending;
    int   mismatches;
    int   idle_pct;
    int   stall_pct;
    int   cur_max;

    int unsigned max_tbl[8]   = '{3, 0, 65535, 7, 1, 2, 12, 5};
    int unsigned scale_tbl[8] = '{1, 15, 2, 4, 0, 7, 3, 15};

    stp_req_if req();
    stp_res_if res();
    stp_cfg_if cfg();

    stepper_axis_step_dir_generator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    axis_motion_checker motion_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .res        (res),
        .cfg        (cfg),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ends the run if no request, result or register write moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stepper_axis_step_dir_generator verification failed");
        $finish;
    end

    task automatic send_req(input logic kind, input logic [BYTE_W-1:0] pb,
                            input logic [BYTE_W-1:0] sb);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.req_type      <= kind;
        req.position_byte <= pb;
        req.speed_byte    <= sb;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // drop valid, let every result come back, then allow the pipeline to settle
    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_idle();
        if (idx == CFG_MAX_HALF_PERIOD)
            cur_max = value;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_item();
        logic             kind;
        logic [BYTE_W-1:0] pb;
        logic [BYTE_W-1:0] sb;
        kind = ($urandom_range(0, 99) < 8) ? REQ_FRAME : REQ_TICK;
        pb   = ($urandom_range(0, 9) < 4) ? BYTE_W'($urandom_range(0, 3))
                                          : BYTE_W'($urandom_range(0, 255));
        // with a large max only the top speed keeps the halves short
        if (cur_max > 255 && $urandom_range(0, 3) != 0)
            sb = 8'd255;
        else
            sb = BYTE_W'($urandom_range(0, 255));
        send_req(kind, pb, sb);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        cur_max           = 20;
        req.valid         = 1'b0;
        req.req_type      = REQ_TICK;
        req.position_byte = '0;
        req.speed_byte    = '0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_MAX_HALF_PERIOD;
        cfg.data          = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: ticks at target, then steps up and down
        send_req(REQ_TICK, 8'd0, 8'd0);
        send_req(REQ_TICK, 8'hFF, 8'hFF);
        send_req(REQ_FRAME, 8'd2, 8'd255);
        repeat (3) send_req(REQ_TICK, 8'd0, 8'd0);
        send_req(REQ_FRAME, 8'd0, 8'd0);
        repeat (2) send_req(REQ_TICK, 8'd0, 8'd0);
        send_req(REQ_FRAME, 8'd1, 8'd128);

        // largest max and scale, fastest speed
        write_reg(CFG_MAX_HALF_PERIOD, 65535);
        write_reg(CFG_TARGET_SCALE, 15);
        send_req(REQ_FRAME, 8'd255, 8'd255);
        repeat (3) send_req(REQ_TICK, 8'd0, 8'd0);

        // zero max and zero scale: target collapses to zero
        write_reg(CFG_MAX_HALF_PERIOD, 0);
        write_reg(CFG_TARGET_SCALE, 0);
        send_req(REQ_FRAME, 8'd200, 8'd17);
        repeat (3) send_req(REQ_TICK, 8'd0, 8'd0);

        for (int seg = 0; seg < 8; seg++)
        begin
            write_reg(CFG_MAX_HALF_PERIOD, max_tbl[seg]);
            write_reg(CFG_TARGET_SCALE, scale_tbl[seg]);
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 6; stall_pct = 6; end
            endcase
            repeat (SEG_ITEMS) random_item();
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("stepper_axis_step_dir_generator verification clean");
        else
            $display("stepper_axis_step_dir_generator verification failed");
        $finish;
    end

endmodule
